// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("invariant check failed");

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication check failed");

`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication check failed");

`else

`define ASSERT_ALWAYS(label, clk, rst_n, prop)
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/core/skt_pkg.sv =====
// ----------------------------------------------------------------------------
// skt_pkg
// Field widths, command and status codes, and shared types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package skt_pkg;

  localparam int KIND_W   = 3;
  localparam int POS_W    = 4;
  localparam int DIST_W   = 14;
  localparam int STATUS_W = 3;
  localparam int OIDX_W   = 4;
  localparam int OCNT_W   = 5;

  typedef logic [KIND_W-1:0]   kind_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam kind_t KIND_INSERT  = 3'd0;
  localparam kind_t KIND_DELETE  = 3'd1;
  localparam kind_t KIND_MODIFY  = 3'd2;
  localparam kind_t KIND_SET_SEL = 3'd3;
  localparam kind_t KIND_SET_PRI = 3'd4;
  localparam kind_t KIND_CLEAR   = 3'd5;
  localparam kind_t KIND_READ    = 3'd6;

  localparam status_t ST_OK       = 3'd0;
  localparam status_t ST_BAD_DIST = 3'd1;
  localparam status_t ST_FULL     = 3'd2;
  localparam status_t ST_DUP      = 3'd3;
  localparam status_t ST_BAD_IDX  = 3'd4;

  localparam logic [DIST_W-1:0] LARGEST_RST = 14'd9999;

  // register index taken from paddr[2]
  localparam logic REG_LARGEST = 1'b0;

  typedef struct packed {
    logic capture;
    logic commit;
  } dp_cmd_t;

endpackage

// ===== rtl/core/skt_ctrl.sv =====
// ----------------------------------------------------------------------------
// skt_ctrl
// Two-state sequencer: capture an item, then commit it to the table and
// the output register once that register is free.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module skt_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  output skt_pkg::dp_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_APPLY = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_stall    = (state_r != ST_IDLE);
  assign cmd.capture = in_valid && (state_r == ST_IDLE);
  assign cmd.commit  = (state_r == ST_APPLY) && !(out_valid_r && out_stall);
  assign out_valid   = out_valid_r;

  assign out_valid_nxt = cmd.commit || (out_valid_r && out_stall);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (cmd.capture) state_nxt = ST_APPLY;
      ST_APPLY: if (cmd.commit) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `ASSERT_ALWAYS(a_state_onehot, clk, rst_n, $onehot(state_r))
  `ASSERT_NEXT(a_capture_to_apply, clk, rst_n, cmd.capture, state_r == ST_APPLY)
  `ASSERT_NEXT(a_commit_shows_item, clk, rst_n, cmd.commit, out_valid_r)

endmodule

// ===== rtl/core/skt_dp.sv =====
// ----------------------------------------------------------------------------
// skt_dp
// Key cell chain with per-cell compare, cursors, count and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module skt_dp #(
  parameter int CAPACITY = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  skt_pkg::dp_cmd_t               cmd,
  input  logic [skt_pkg::DIST_W-1:0]     largest,
  input  logic [skt_pkg::KIND_W-1:0]     in_kind,
  input  logic [skt_pkg::POS_W-1:0]      in_position,
  input  logic [skt_pkg::DIST_W-1:0]     in_distance,
  output logic [skt_pkg::STATUS_W-1:0]   out_status,
  output logic [skt_pkg::OIDX_W-1:0]     out_result_index,
  output logic [skt_pkg::OCNT_W-1:0]     out_entry_count,
  output logic [skt_pkg::OIDX_W-1:0]     out_selected_index,
  output logic [skt_pkg::OIDX_W-1:0]     out_primary_index,
  output logic [skt_pkg::DIST_W-1:0]     out_read_distance
);

  localparam int IW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > skt_pkg::POS_W) ? CW : skt_pkg::POS_W;
  localparam int DW   = skt_pkg::DIST_W;
  localparam int OIW  = skt_pkg::OIDX_W;
  localparam int OCW  = skt_pkg::OCNT_W;

  // table state
  logic [DW-1:0] keys_r [CAPACITY];
  logic [DW-1:0] keys_nxt [CAPACITY];
  logic [DW-1:0] key_below [CAPACITY];
  logic [DW-1:0] key_above [CAPACITY];
  logic [CW-1:0] count_r, count_nxt;
  logic [IW-1:0] sel_r, sel_nxt, pri_r, pri_nxt;

  // capture stage
  logic [CMPW-1:0]        pos_ext;
  logic                   pos_bad, key_ok, full, dup;
  logic [CAPACITY-1:0]    lt_c, eq_c;
  skt_pkg::status_t       st_c;
  logic [DW-1:0]          rd_c;

  skt_pkg::kind_t         kind_r;
  logic [IW-1:0]          pos_r;
  logic [DW-1:0]          dist_r;
  skt_pkg::status_t       status_r;
  logic [CAPACITY-1:0]    lt_r;
  logic [DW-1:0]          rd_r;

  // apply stage
  logic [CAPACITY-1:0]    lt_prev;
  logic [CW-1:0]          first_ge, to_w;
  logic [IW-1:0]          at_i, to_i, res_idx;
  logic                   apply_ok;
  logic [DW-1:0]          rd_out;

  // output register
  skt_pkg::status_t       out_status_r;
  logic [OIW-1:0]         out_result_index_r, out_selected_index_r, out_primary_index_r;
  logic [OCW-1:0]         out_entry_count_r;
  logic [DW-1:0]          out_read_distance_r;

  function automatic logic [IW-1:0] follow_move(input logic [IW-1:0] cur,
                                                input logic [IW-1:0] src,
                                                input logic [IW-1:0] dst);
    logic [IW-1:0] res;
    res = cur;
    if (cur == src) res = dst;
    else if (src < dst && cur > src && cur <= dst) res = cur - IW'(1);
    else if (dst < src && cur >= dst && cur < src) res = cur + IW'(1);
    return res;
  endfunction

  for (genvar g = 0; g < CAPACITY; g++) begin : g_nb
    if (g == 0) begin : g_lo
      assign key_below[g] = keys_r[g];
    end else begin : g_lo_n
      assign key_below[g] = keys_r[g-1];
    end
    if (g == CAPACITY - 1) begin : g_hi
      assign key_above[g] = keys_r[g];
    end else begin : g_hi_n
      assign key_above[g] = keys_r[g+1];
    end
  end

  // ---------------- capture: per-cell compare and checks ----------------
  assign pos_ext = CMPW'(in_position);
  assign pos_bad = pos_ext >= CMPW'(count_r);
  assign key_ok  = (in_distance != '0) && (in_distance <= largest);
  assign full    = count_r >= CW'(CAPACITY);
  assign rd_c    = keys_r[pos_ext[IW-1:0]];
  assign dup     = |eq_c;

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      lt_c[i] = (CW'(i) < count_r) && (keys_r[i] < in_distance);
      eq_c[i] = (CW'(i) < count_r) && (keys_r[i] == in_distance) &&
                !((in_kind == skt_pkg::KIND_MODIFY) && (CMPW'(i) == pos_ext));
    end
  end

  always_comb begin
    st_c = skt_pkg::ST_OK;
    unique case (in_kind)
      skt_pkg::KIND_INSERT: begin
        priority if (!key_ok) st_c = skt_pkg::ST_BAD_DIST;
        else if (full)        st_c = skt_pkg::ST_FULL;
        else if (dup)         st_c = skt_pkg::ST_DUP;
        else                  st_c = skt_pkg::ST_OK;
      end
      skt_pkg::KIND_MODIFY: begin
        priority if (pos_bad) st_c = skt_pkg::ST_BAD_IDX;
        else if (!key_ok)     st_c = skt_pkg::ST_BAD_DIST;
        else if (dup)         st_c = skt_pkg::ST_DUP;
        else                  st_c = skt_pkg::ST_OK;
      end
      skt_pkg::KIND_DELETE, skt_pkg::KIND_SET_SEL,
      skt_pkg::KIND_SET_PRI, skt_pkg::KIND_READ: begin
        st_c = pos_bad ? skt_pkg::ST_BAD_IDX : skt_pkg::ST_OK;
      end
      default: st_c = skt_pkg::ST_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r   <= in_kind;
      pos_r    <= pos_ext[IW-1:0];
      dist_r   <= in_distance;
      status_r <= st_c;
      lt_r     <= lt_c;
      rd_r     <= rd_c;
    end
  end

  // ---------------- apply: placement and cursor update ----------------
  // lt_r is a run of ones from cell 0; its end is the sorted position
  assign lt_prev = {lt_r[CAPACITY-2:0], 1'b1};

  always_comb begin
    first_ge = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      first_ge = first_ge | ((!lt_r[i] && lt_prev[i]) ? CW'(i) : CW'(0));
    end
    if (&lt_r) first_ge = CW'(CAPACITY);
  end

  assign to_w     = first_ge - CW'(lt_r[pos_r]);
  assign to_i     = to_w[IW-1:0];
  assign at_i     = first_ge[IW-1:0];
  assign apply_ok = (status_r == skt_pkg::ST_OK);

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      keys_nxt[i] = keys_r[i];
      unique case (kind_r)
        skt_pkg::KIND_INSERT: begin
          if (IW'(i) == at_i) keys_nxt[i] = dist_r;
          else if (IW'(i) > at_i) keys_nxt[i] = key_below[i];
        end
        skt_pkg::KIND_DELETE: begin
          if (IW'(i) >= pos_r) keys_nxt[i] = key_above[i];
        end
        skt_pkg::KIND_MODIFY: begin
          if (IW'(i) == to_i) keys_nxt[i] = dist_r;
          else if (to_i > pos_r && IW'(i) >= pos_r && IW'(i) < to_i)
            keys_nxt[i] = key_above[i];
          else if (to_i < pos_r && IW'(i) > to_i && IW'(i) <= pos_r)
            keys_nxt[i] = key_below[i];
        end
        default: keys_nxt[i] = keys_r[i];
      endcase
    end
  end

  always_comb begin
    count_nxt = count_r;
    sel_nxt   = sel_r;
    pri_nxt   = pri_r;
    res_idx   = '0;
    rd_out    = '0;
    if (apply_ok) begin
      unique case (kind_r)
        skt_pkg::KIND_INSERT: begin
          count_nxt = count_r + CW'(1);
          res_idx   = at_i;
          if (count_r == '0) begin
            sel_nxt = '0;
            pri_nxt = '0;
          end else begin
            sel_nxt = (sel_r >= at_i) ? sel_r + IW'(1) : sel_r;
            pri_nxt = (pri_r >= at_i) ? pri_r + IW'(1) : pri_r;
          end
        end
        skt_pkg::KIND_DELETE: begin
          count_nxt = count_r - CW'(1);
          if (count_r == CW'(1)) begin
            sel_nxt = '0;
            pri_nxt = '0;
          end else begin
            if (sel_r == pos_r) sel_nxt = (pos_r == '0) ? '0 : pos_r - IW'(1);
            else if (sel_r > pos_r) sel_nxt = sel_r - IW'(1);
            if (pri_r == pos_r) pri_nxt = '0;
            else if (pri_r > pos_r) pri_nxt = pri_r - IW'(1);
          end
        end
        skt_pkg::KIND_MODIFY: begin
          res_idx = to_i;
          sel_nxt = follow_move(sel_r, pos_r, to_i);
          pri_nxt = follow_move(pri_r, pos_r, to_i);
        end
        skt_pkg::KIND_SET_SEL: sel_nxt = pos_r;
        skt_pkg::KIND_SET_PRI: pri_nxt = pos_r;
        skt_pkg::KIND_CLEAR: begin
          count_nxt = '0;
          sel_nxt   = '0;
          pri_nxt   = '0;
        end
        skt_pkg::KIND_READ: rd_out = rd_r;
        default: rd_out = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      sel_r   <= '0;
      pri_r   <= '0;
    end else if (cmd.commit) begin
      count_r <= count_nxt;
      sel_r   <= sel_nxt;
      pri_r   <= pri_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && apply_ok) keys_r <= keys_nxt;
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_status_r         <= status_r;
      out_result_index_r   <= OIW'(res_idx);
      out_entry_count_r    <= OCW'(count_nxt);
      out_selected_index_r <= OIW'(sel_nxt);
      out_primary_index_r  <= OIW'(pri_nxt);
      out_read_distance_r  <= rd_out;
    end
  end

  assign out_status         = out_status_r;
  assign out_result_index   = out_result_index_r;
  assign out_entry_count    = out_entry_count_r;
  assign out_selected_index = out_selected_index_r;
  assign out_primary_index  = out_primary_index_r;
  assign out_read_distance  = out_read_distance_r;

  `ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_r <= CW'(CAPACITY))
  `ASSERT_IMPLY(a_cursors_in_table, clk, rst_n, count_r != '0,
                (CW'(sel_r) < count_r) && (CW'(pri_r) < count_r))
  `ASSERT_IMPLY(a_cursors_empty, clk, rst_n, count_r == '0,
                (sel_r == '0) && (pri_r == '0))

endmodule

// ===== rtl/core/sorted_key_table_with_cursors.sv =====
// ----------------------------------------------------------------------------
// sorted_key_table_with_cursors
// Ascending table of unique distance keys with selected and primary cursors.
// ----------------------------------------------------------------------------
//   channel | direction | handshake              | payload
//   in      | input     | in_valid / in_stall    | kind, position, distance
//   out     | output    | out_valid / out_stall  | status, result_index,
//           |           |                        | entry_count, selected_index,
//           |           |                        | primary_index, read_distance
//   cfg     | input     | psel / penable / pready| largest_distance at 0x0
//
// Each item has a capture step, which compares the key against every cell, and
// an apply step, which shifts the cell chain and loads the output register.
// A new item is taken while the previous result still waits in the output
// register; the commit cycle waits while out_stall holds that register.
// Reset clears count and cursors; key cells are not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_key_table_with_cursors #(
  parameter int CAPACITY = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [skt_pkg::KIND_W-1:0]     in_kind,
  input  logic [skt_pkg::POS_W-1:0]      in_position,
  input  logic [skt_pkg::DIST_W-1:0]     in_distance,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [skt_pkg::STATUS_W-1:0]   out_status,
  output logic [skt_pkg::OIDX_W-1:0]     out_result_index,
  output logic [skt_pkg::OCNT_W-1:0]     out_entry_count,
  output logic [skt_pkg::OIDX_W-1:0]     out_selected_index,
  output logic [skt_pkg::OIDX_W-1:0]     out_primary_index,
  output logic [skt_pkg::DIST_W-1:0]     out_read_distance,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [2:0]                     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  skt_pkg::dp_cmd_t                 cmd;
  logic [skt_pkg::DIST_W-1:0]       largest_r;
  logic                             reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == skt_pkg::REG_LARGEST);
  assign prdata  = reg_hit ? 32'(largest_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      largest_r <= skt_pkg::LARGEST_RST;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      largest_r <= pwdata[skt_pkg::DIST_W-1:0];
    end
  end

  skt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  skt_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .largest            (largest_r),
    .in_kind            (in_kind),
    .in_position        (in_position),
    .in_distance        (in_distance),
    .out_status         (out_status),
    .out_result_index   (out_result_index),
    .out_entry_count    (out_entry_count),
    .out_selected_index (out_selected_index),
    .out_primary_index  (out_primary_index),
    .out_read_distance  (out_read_distance)
  );

endmodule
